@@ src/double_lores_picture_loader_defines.svh @@
// Assertion macros for the double lo-res picture loader checker.
`ifndef DOUBLE_LORES_PICTURE_LOADER_DEFINES_SVH
`define DOUBLE_LORES_PICTURE_LOADER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DLPL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define DLPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dlpl_pkg.sv @@
// Shared types, codes and helpers for the double lo-res picture loader.
package dlpl_pkg;

  localparam int BANK_BYTES    = 1024;
  localparam int ADDR_W        = $clog2(BANK_BYTES);
  localparam int GRID_WIDTH    = 80;
  localparam int GRID_HEIGHT   = 48;
  localparam int ROW_BYTES     = 40;
  localparam int TEXT_ROWS     = 24;
  localparam int COUNT_MAX     = 4095;
  localparam int ROW_COUNT_MAX = 63;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] FMT_RAW    = 2'd0;
  localparam logic [1:0] FMT_ROWS   = 2'd1;
  localparam logic [1:0] FMT_PIXMAP = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_SKIP    = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  localparam logic [2:0] REG_FORMAT_MODE    = 3'd0;
  localparam logic [2:0] REG_DOUBLE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_PICTURE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_PICTURE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RAW_LENGTH     = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WRITE,
    OP_RMW,
    OP_READ
  } op_kind_t;

  // One classified request as handed from front to back.
  typedef struct packed {
    op_kind_t          kind;
    logic              aux;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              hi;
    logic [1:0]        status;
  } op_t;

  typedef struct packed {
    logic init_sweep;
  } back_status_t;

  // Interleaved text row base: 128 bytes per row within a third, 40 per third.
  function automatic logic [ADDR_W-1:0] text_row_base(input logic [4:0] r);
    logic [ADDR_W-1:0] third;
    case (r[4:3])
      2'd0:    third = '0;
      2'd1:    third = ADDR_W'(ROW_BYTES);
      2'd2:    third = ADDR_W'(2 * ROW_BYTES);
      default: third = ADDR_W'(3 * ROW_BYTES);
    endcase
    return {r[2:0], 7'b0} + third;
  endfunction

endpackage

@@ src/dlpl_front.sv @@
// Front end: config registers, load counters and request classification.
module dlpl_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [11:0]          cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           cmd,
  input  logic [7:0]           data_byte,
  input  logic                 read_bank,
  input  logic [9:0]           read_address,
  input  logic                 q_full,
  input  dlpl_pkg::back_status_t back_status,
  output logic                 push,
  output dlpl_pkg::op_t        push_op
);
  import dlpl_pkg::*;

  logic [1:0]  format_mode;
  logic        double_width;
  logic [6:0]  picture_width;
  logic [5:0]  picture_height;
  logic [11:0] raw_length;

  logic [11:0] byte_count, byte_count_next;
  logic [6:0]  column_count, column_count_next;
  logic [6:0]  row_count, row_count_next;
  logic        second_half, second_half_next;

  logic [4:0]  lines_raw, lines;
  logic [6:0]  pix_w;
  logic [5:0]  pix_h;
  logic [10:0] half_len;
  logic [11:0] rel_pos;
  logic [6:0]  c1, r1, c2, r2;
  logic        half_n;
  logic [6:0]  x_pos;
  logic [5:0]  y_pos;

  assign cfg_ready  = 1'b1;
  assign item_stall = q_full || back_status.init_sweep;
  assign push       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode    <= FMT_RAW;
      double_width   <= 1'b0;
      picture_width  <= 7'(GRID_WIDTH);
      picture_height <= 6'(GRID_HEIGHT);
      raw_length     <= 12'(BANK_BYTES);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT_MODE:    format_mode    <= cfg_data[1:0];
        REG_DOUBLE_WIDTH:   double_width   <= cfg_data[0];
        REG_PICTURE_WIDTH:  picture_width  <= cfg_data[6:0];
        REG_PICTURE_HEIGHT: picture_height <= cfg_data[5:0];
        REG_RAW_LENGTH:     raw_length     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      column_count <= '0;
      row_count    <= '0;
      second_half  <= 1'b0;
    end else if (push) begin
      byte_count   <= byte_count_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      second_half  <= second_half_next;
    end
  end

  always_comb begin
    push_op           = '0;
    push_op.kind      = OP_NONE;
    push_op.status    = STAT_DONE;
    byte_count_next   = byte_count;
    column_count_next = column_count;
    row_count_next    = row_count;
    second_half_next  = second_half;

    lines_raw = picture_height[5:1];
    lines     = (lines_raw > 5'(TEXT_ROWS)) ? 5'(TEXT_ROWS) : lines_raw;
    pix_w     = (picture_width > 7'(GRID_WIDTH)) ? 7'(GRID_WIDTH) : picture_width;
    pix_h     = (picture_height > 6'(GRID_HEIGHT)) ? 6'(GRID_HEIGHT) : picture_height;
    half_len  = raw_length[11:1];
    rel_pos   = byte_count - {1'b0, half_len};
    c1        = column_count;
    r1        = row_count;
    c2        = column_count;
    r2        = row_count;
    half_n    = second_half;
    x_pos     = '0;
    y_pos     = '0;

    case (cmd)
      CMD_CLEAR: begin
        push_op.kind      = OP_CLEAR;
        byte_count_next   = '0;
        column_count_next = '0;
        row_count_next    = '0;
        second_half_next  = 1'b0;
      end
      CMD_LOAD: begin
        case (format_mode)
          FMT_RAW: begin
            push_op.status = STAT_IGNORED;
            push_op.data   = data_byte;
            if (byte_count != 12'(COUNT_MAX)) byte_count_next = byte_count + 12'd1;
            if (raw_length > 12'(BANK_BYTES)) begin
              // split file: first half aux, second half main
              if (byte_count < {1'b0, half_len}) begin
                if (byte_count < 12'(BANK_BYTES)) begin
                  push_op.kind   = OP_WRITE;
                  push_op.aux    = 1'b1;
                  push_op.addr   = byte_count[ADDR_W-1:0];
                  push_op.status = STAT_DONE;
                end
              end else if (byte_count < {half_len, 1'b0}) begin
                if (rel_pos < 12'(BANK_BYTES)) begin
                  push_op.kind   = OP_WRITE;
                  push_op.addr   = rel_pos[ADDR_W-1:0];
                  push_op.status = STAT_DONE;
                end
              end
            end else if (byte_count < raw_length) begin
              push_op.kind   = OP_WRITE;
              push_op.addr   = byte_count[ADDR_W-1:0];
              push_op.status = STAT_DONE;
            end
          end
          FMT_ROWS: begin
            // any row count past the grid acts alike, so it can saturate
            if (column_count >= 7'(ROW_BYTES)) begin
              c1 = '0;
              r1 = (row_count < 7'(ROW_COUNT_MAX)) ? row_count + 7'd1 : row_count;
            end
            if (r1 >= {2'b0, lines} && double_width && !second_half) begin
              half_n = 1'b1;
              r1     = '0;
              c1     = '0;
            end
            column_count_next = c1;
            row_count_next    = r1;
            second_half_next  = half_n;
            if (r1 >= {2'b0, lines}) begin
              push_op.status = STAT_IGNORED;
            end else begin
              push_op.kind = OP_WRITE;
              push_op.aux  = double_width && !half_n;
              push_op.addr = text_row_base(r1[4:0]) + ADDR_W'(c1);
              push_op.data = data_byte;
              c2 = c1 + 7'd1;
              r2 = r1;
              if (c2 >= 7'(ROW_BYTES)) begin
                c2 = '0;
                r2 = r1 + 7'd1;
              end
              column_count_next = c2;
              row_count_next    = r2;
            end
          end
          FMT_PIXMAP: begin
            if (pix_w == 7'd0 || pix_h == 6'd0) begin
              push_op.status = STAT_IGNORED;
            end else begin
              if (column_count >= pix_w) begin
                c1 = '0;
                r1 = (row_count < 7'(ROW_COUNT_MAX)) ? row_count + 7'd1 : row_count;
              end
              column_count_next = c1;
              row_count_next    = r1;
              if (r1 >= {1'b0, pix_h}) begin
                push_op.status = STAT_IGNORED;
              end else begin
                // center on the grid; two pixels per byte column, two rows per byte
                x_pos = ((7'(GRID_WIDTH) - pix_w) >> 1) + c1;
                y_pos = ((6'(GRID_HEIGHT) - pix_h) >> 1) + r1[5:0];
                push_op.addr = text_row_base(y_pos[5:1]) + ADDR_W'(x_pos[6:1]);
                push_op.aux  = !x_pos[0];
                push_op.hi   = y_pos[0];
                push_op.data = {4'b0, data_byte[3:0]};
                if (data_byte[7:4] != 4'd0) begin
                  push_op.kind   = OP_RMW;
                  push_op.status = STAT_DONE;
                end else begin
                  push_op.status = STAT_SKIP;
                end
                c2 = c1 + 7'd1;
                r2 = r1;
                if (c2 >= pix_w) begin
                  c2 = '0;
                  if (r1 < 7'(ROW_COUNT_MAX)) r2 = r1 + 7'd1;
                end
                column_count_next = c2;
                row_count_next    = r2;
              end
            end
          end
          default: push_op.status = STAT_IGNORED;
        endcase
      end
      CMD_READ: begin
        push_op.kind = OP_READ;
        push_op.aux  = read_bank;
        push_op.addr = read_address;
      end
      default: ;
    endcase
  end

endmodule

@@ src/dlpl_queue.sv @@
// Small request queue between the front and back ends.
module dlpl_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dlpl_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output dlpl_pkg::op_t head,
  output logic          empty
);
  import dlpl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

@@ src/dlpl_back.sv @@
// Back end: the two bank memories, clear sweep, RMW and read, result register.
module dlpl_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  dlpl_pkg::op_t          head,
  output logic                   pop,
  output dlpl_pkg::back_status_t back_status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             read_data,
  output logic [1:0]             load_status
);
  import dlpl_pkg::*;

  typedef enum logic [3:0] {
    B_SWEEP = 4'b0001,
    B_RUN   = 4'b0010,
    B_RMW   = 4'b0100,
    B_READ  = 4'b1000
  } back_state_t;

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] sweep_cnt, sweep_cnt_next;
  logic              sweep_report, sweep_report_next;

  logic              cur_aux;
  logic [ADDR_W-1:0] cur_addr;
  logic [3:0]        cur_data;
  logic              cur_hi;

  logic [7:0]        aux_mem  [BANK_BYTES];
  logic [7:0]        main_mem [BANK_BYTES];
  logic [7:0]        aux_q, main_q, rd_word;

  logic              we_aux, we_main;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              done;
  logic [7:0]        done_data;
  logic [1:0]        done_status;
  logic              out_free;

  assign back_status.init_sweep = (state == B_SWEEP) && !sweep_report;

  always_comb begin
    state_next        = state;
    sweep_cnt_next    = sweep_cnt;
    sweep_report_next = sweep_report;
    pop               = 1'b0;
    done              = 1'b0;
    done_data         = '0;
    done_status       = STAT_DONE;
    we_aux            = 1'b0;
    we_main           = 1'b0;
    waddr             = head.addr;
    wdata             = head.data;
    out_free          = !result_valid || !result_stall;
    rd_word           = cur_aux ? aux_q : main_q;

    case (state)
      B_SWEEP: begin
        we_aux         = 1'b1;
        we_main        = 1'b1;
        waddr          = sweep_cnt;
        wdata          = '0;
        sweep_cnt_next = sweep_cnt + ADDR_W'(1);
        if (sweep_cnt == ADDR_W'(BANK_BYTES - 1)) begin
          state_next = B_RUN;
          done       = sweep_report;  // the sweep after reset gives no result
        end
      end
      B_RUN: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          case (head.kind)
            OP_CLEAR: begin
              state_next        = B_SWEEP;
              sweep_report_next = 1'b1;
              sweep_cnt_next    = '0;
            end
            OP_WRITE: begin
              we_aux      = head.aux;
              we_main     = !head.aux;
              done        = 1'b1;
              done_status = head.status;
            end
            OP_RMW:  state_next = B_RMW;
            OP_READ: state_next = B_READ;
            default: begin
              done        = 1'b1;
              done_status = head.status;
            end
          endcase
        end
      end
      B_RMW: begin
        we_aux     = cur_aux;
        we_main    = !cur_aux;
        waddr      = cur_addr;
        wdata      = cur_hi ? {cur_data, rd_word[3:0]} : {rd_word[7:4], cur_data};
        done       = 1'b1;
        state_next = B_RUN;
      end
      B_READ: begin
        done       = 1'b1;
        done_data  = rd_word;
        state_next = B_RUN;
      end
      default: state_next = B_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_SWEEP;
      sweep_cnt    <= '0;
      sweep_report <= 1'b0;
    end else begin
      state        <= state_next;
      sweep_cnt    <= sweep_cnt_next;
      sweep_report <= sweep_report_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_aux  <= head.aux;
      cur_addr <= head.addr;
      cur_data <= head.data[3:0];
      cur_hi   <= head.hi;
    end
  end

  // read port follows the queue head; data is used the cycle after the pop
  always_ff @(posedge clk) begin
    aux_q  <= aux_mem[head.addr];
    main_q <= main_mem[head.addr];
  end

  always_ff @(posedge clk) begin
    if (we_aux) aux_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (we_main) main_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      read_data   <= done_data;
      load_status <= done_status;
    end
  end

endmodule

@@ src/double_lores_picture_loader.sv @@
// Top level of the double lo-res picture loader.
// Takes picture file bytes and commands on the item channel and places them in two
// 1024-byte banks (main and auxiliary) of a lo-res text-page store, in raw, hole-free
// row or masked pixmap format as set by the config registers; one result per request.
// After reset the block sweeps both banks to zero and holds item_stall high meanwhile;
// config writes are taken at any time. The front end takes one request per cycle while
// its queue has room and no init sweep runs. In the back end a plain write or a skipped
// or ignored byte is finished as it is taken from the queue; a pixmap pixel or a read
// also needs a second state (the bank read is registered, so the write-back or the
// result comes the cycle after), and a clear is taken from the queue, then the sweep
// clears one address of both banks per cycle.
module double_lores_picture_loader #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic        read_bank,
  input  logic [9:0]  read_address,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  read_data,
  output logic [1:0]  load_status
);
  import dlpl_pkg::*;

  logic         push, pop, q_full, q_empty;
  op_t          push_op, head;
  back_status_t back_status;

  dlpl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .read_bank    (read_bank),
    .read_address (read_address),
    .q_full       (q_full),
    .back_status  (back_status),
    .push         (push),
    .push_op      (push_op)
  );

  dlpl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty)
  );

  dlpl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .back_status  (back_status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .read_data    (read_data),
    .load_status  (load_status)
  );

endmodule

@@ src/dlpl_checker.sv @@
// Port-level checker for the double lo-res picture loader, bound to the top level.
`include "double_lores_picture_loader_defines.svh"

module dlpl_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] read_data,
  input logic [1:0] load_status
);
  import dlpl_pkg::*;

  logic [7:0] pending;

  // requests taken minus results delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({item_valid && !item_stall, result_valid && !result_stall})
        2'b10:   pending <= pending + 8'd1;
        2'b01:   pending <= pending - 8'd1;
        default: ;
      endcase
    end
  end

  `DLPL_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(read_data) && $stable(load_status), "stalled result changed")
  `DLPL_ASSERT_IMPLY(a_no_extra_result, result_valid, pending != 8'd0, "result without a request")
  `DLPL_ASSERT_IMPLY(a_read_status, result_valid && read_data != 8'd0, load_status == STAT_DONE, "read data with load status")
  `DLPL_ASSERT_IMPLY(a_init_sweep_stall, $fell(rst), item_stall, "request taken during init sweep")

endmodule

bind double_lores_picture_loader dlpl_port_checker u_chk (.*);
